// File: rtl/cll_pkg.sv
// types and constants shared by the cursor linked list engine modules
// no dependencies

package cll_pkg;

   localparam int CMD_WIDTH    = 2;
   localparam int POS_WIDTH    = 10;
   localparam int VALUE_WIDTH  = 32;
   localparam int STATUS_WIDTH = 2;

   localparam logic [CMD_WIDTH-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_GET    = 2'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_LOCATE = 2'd3;

   localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]          cmd;
      logic [POS_WIDTH-1:0]          position;
      logic signed [VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] result_value;
      logic [POS_WIDTH-1:0]          found_position;
      logic [STATUS_WIDTH-1:0]       status;
      logic [POS_WIDTH-1:0]          list_length;
   } rsp_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_ERR,
      DP_START,
      DP_STEP,
      DP_MARK_INS,
      DP_MARK_DEL,
      DP_INS_LINK,
      DP_DEL_LINK,
      DP_WR_PREV,
      DP_GET,
      DP_FOUND,
      DP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]    cmd;
      logic [STATUS_WIDTH-1:0] err;
      logic                    walk_done;
      logic                    loc_hit;
      logic                    loc_end;
   } dp_status_type;

endpackage

// File: rtl/cll_dp.sv
// datapath: link and value stores, walk cursor, free chain, result registers
// depends on cll_pkg

module cll_dp #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cll_pkg::dp_cmd_type    dp_cmd,
   output cll_pkg::dp_status_type dp_status,
   input  cll_pkg::req_type       req_data,
   output cll_pkg::rsp_type       rsp_data
);
   import cll_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int VW = (DATA_WIDTH < VALUE_WIDTH) ? DATA_WIDTH : VALUE_WIDTH;
   localparam int CW = ((AW > POS_WIDTH) ? AW : POS_WIDTH) + 1;

   logic [AW-1:0] link_mem [DEPTH];
   logic [VW-1:0] val_mem  [DEPTH];
   logic [AW-1:0] link_q;
   logic [VW-1:0] value_q;

   logic [CMD_WIDTH-1:0]    cmd_ff;
   logic [POS_WIDTH-1:0]    pos_ff;
   logic [VW-1:0]           val_ff;
   logic [AW-1:0]           count_ff, count_in;
   logic [AW-1:0]           free_ff, free_in;
   logic [AW-1:0]           mark_ff, mark_in;
   logic [AW-1:0]           head_ff, head_in;
   logic [AW-1:0]           rd_slot_ff;
   logic [AW-1:0]           prev_ff;
   logic [AW-1:0]           hold_ff;
   logic [AW-1:0]           steps_ff;
   logic [VW-1:0]           res_ff;
   logic [AW-1:0]           found_ff;
   logic [STATUS_WIDTH-1:0] status_ff;
   rsp_type                 out_ff;

   logic [AW-1:0] next_slot;
   logic [AW-1:0] raddr;
   logic          link_we;
   logic          val_we;
   logic [AW-1:0] link_wa;
   logic [AW-1:0] link_wd;
   logic [AW-1:0] target;
   logic [CW-1:0] pos_x;
   logic [CW-1:0] cnt_x;
   logic          pos_zero;
   logic          ins_range;
   logic          acc_range;
   logic          list_full;

   // slots at or above the mark were never allocated; their link is taken as the next slot, not read from the store
   always_comb begin
      if (rd_slot_ff == '0) begin
         next_slot = head_ff;
      end else if (rd_slot_ff >= mark_ff) begin
         next_slot = (rd_slot_ff == AW'(DEPTH - 1)) ? '0 : rd_slot_ff + AW'(1);
      end else begin
         next_slot = link_q;
      end
   end

   always_comb begin
      case (dp_cmd.op) inside
         DP_START:             raddr = '0;
         DP_STEP, DP_MARK_DEL: raddr = next_slot;
         DP_MARK_INS:          raddr = free_ff;
         default:              raddr = rd_slot_ff;
      endcase
   end

   always_comb begin
      link_we = 1'b0;
      val_we  = 1'b0;
      link_wa = rd_slot_ff;
      link_wd = hold_ff;
      case (dp_cmd.op)
         DP_INS_LINK: begin
            link_we = 1'b1;
            val_we  = 1'b1;
         end
         DP_DEL_LINK: begin
            link_we = 1'b1;
            link_wd = free_ff;
         end
         DP_WR_PREV: begin
            link_we = 1'b1;
            link_wa = prev_ff;
            link_wd = (cmd_ff == CMD_INSERT) ? rd_slot_ff : hold_ff;
         end
         default: ;
      endcase
   end

   // command checks
   always_comb begin
      pos_x     = CW'(pos_ff);
      cnt_x     = CW'(count_ff);
      pos_zero  = (pos_ff == '0);
      ins_range = pos_zero || (pos_x > cnt_x + CW'(1));
      acc_range = pos_zero || (pos_x > cnt_x);
      list_full = (count_ff >= AW'(DEPTH - 2));
      target    = (cmd_ff == CMD_GET) ? AW'(pos_ff) : AW'(pos_ff) - AW'(1);

      dp_status.cmd = cmd_ff;
      unique case (cmd_ff) inside
         CMD_INSERT: dp_status.err = list_full ? ST_FULL : (ins_range ? ST_RANGE : ST_OK);
         CMD_DELETE,
         CMD_GET:    dp_status.err = acc_range ? ST_RANGE : ST_OK;
         default:    dp_status.err = ST_OK;
      endcase
      dp_status.walk_done = (steps_ff == target);
      dp_status.loc_hit   = (steps_ff != '0) && (value_q == val_ff);
      dp_status.loc_end   = (steps_ff == count_ff);
   end

   always_comb begin
      count_in = count_ff;
      free_in  = free_ff;
      mark_in  = mark_ff;
      head_in  = head_ff;
      case (dp_cmd.op)
         DP_INS_LINK: begin
            count_in = count_ff + AW'(1);
            free_in  = next_slot;
            if (rd_slot_ff == mark_ff) begin
               mark_in = mark_ff + AW'(1);
            end
         end
         DP_DEL_LINK: begin
            count_in = count_ff - AW'(1);
            free_in  = rd_slot_ff;
         end
         default: ;
      endcase
      // slot 0 is the head and lives in a register
      if (link_we && link_wa == '0) begin
         head_in = link_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         free_ff  <= AW'(1);
         mark_ff  <= AW'(1);
         head_ff  <= AW'(1);
      end else begin
         count_ff <= count_in;
         free_ff  <= free_in;
         mark_ff  <= mark_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (link_we && link_wa != '0) begin
         link_mem[link_wa] <= link_wd;
      end
      if (val_we) begin
         val_mem[rd_slot_ff] <= val_ff;
      end
      link_q  <= link_mem[raddr];
      value_q <= val_mem[raddr];
   end

   always_ff @(posedge clock) begin
      rd_slot_ff <= raddr;
      case (dp_cmd.op)
         DP_LOAD: begin
            cmd_ff    <= req_data.cmd;
            pos_ff    <= req_data.position;
            val_ff    <= req_data.value[VW-1:0];
            res_ff    <= '0;
            found_ff  <= '0;
            status_ff <= ST_OK;
         end
         DP_ERR:   status_ff <= dp_status.err;
         DP_START: steps_ff  <= '0;
         DP_STEP:  steps_ff  <= steps_ff + AW'(1);
         DP_MARK_INS: begin
            prev_ff <= rd_slot_ff;
            hold_ff <= next_slot;
         end
         DP_MARK_DEL: prev_ff <= rd_slot_ff;
         DP_DEL_LINK: begin
            res_ff  <= value_q;
            hold_ff <= next_slot;
         end
         DP_GET:   res_ff   <= value_q;
         DP_FOUND: found_ff <= steps_ff;
         DP_PUBLISH: begin
            out_ff.result_value   <= VALUE_WIDTH'(res_ff);
            out_ff.found_position <= POS_WIDTH'(found_ff);
            out_ff.status         <= status_ff;
            out_ff.list_length    <= POS_WIDTH'(count_ff);
         end
         default: ;
      endcase
   end

   assign rsp_data = out_ff;

endmodule

// File: rtl/cll_ctrl.sv
// controller: sequences each command through check, walk and, for insert and delete, commit steps
// depends on cll_pkg

module cll_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cll_pkg::dp_cmd_type    dp_cmd,
   input  cll_pkg::dp_status_type dp_status
);
   import cll_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_WALK,
      S_LOCATE,
      S_INS_LINK,
      S_DEL_LINK,
      S_WR_PREV,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      dp_cmd.op    = DP_NOP;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.op = DP_LOAD;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            if (dp_status.err != ST_OK) begin
               dp_cmd.op = DP_ERR;
               state_in  = S_FINISH;
            end else begin
               dp_cmd.op = DP_START;
               state_in  = (dp_status.cmd == CMD_LOCATE) ? S_LOCATE : S_WALK;
            end
         end
         S_WALK: begin
            if (!dp_status.walk_done) begin
               dp_cmd.op = DP_STEP;
            end else begin
               unique case (dp_status.cmd)
                  CMD_INSERT: begin
                     dp_cmd.op = DP_MARK_INS;
                     state_in  = S_INS_LINK;
                  end
                  CMD_DELETE: begin
                     dp_cmd.op = DP_MARK_DEL;
                     state_in  = S_DEL_LINK;
                  end
                  default: begin
                     dp_cmd.op = DP_GET;
                     state_in  = S_FINISH;
                  end
               endcase
            end
         end
         S_LOCATE: begin
            if (dp_status.loc_hit) begin
               dp_cmd.op = DP_FOUND;
               state_in  = S_FINISH;
            end else if (dp_status.loc_end) begin
               state_in = S_FINISH;
            end else begin
               dp_cmd.op = DP_STEP;
            end
         end
         S_INS_LINK: begin
            dp_cmd.op = DP_INS_LINK;
            state_in  = S_WR_PREV;
         end
         S_DEL_LINK: begin
            dp_cmd.op = DP_DEL_LINK;
            state_in  = S_WR_PREV;
         end
         S_WR_PREV: begin
            dp_cmd.op = DP_WR_PREV;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            // hold until the previous result beat has gone
            if (!rsp_valid_ff || !rsp_stall) begin
               dp_cmd.op    = DP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/cursor_linked_list_engine.sv
// top level of the cursor linked list engine: controller plus datapath
// depends on cll_pkg, cll_ctrl, cll_dp
//
//   channel  ports                            direction
//   req      req_valid, req_stall, req_data   in  (cmd, position, value)
//   rsp      rsp_valid, rsp_stall, rsp_data   out (result_value, found_position,
//                                                  status, list_length)
//
// one command at a time; insert and delete walk to the slot before position p, get to p,
// locate up to the list length n, and a rejected command skips the walk.
// the walk follows next links, one link store read per cycle.
// reset empties the list at once: unallocated slots are tracked by a high-water mark.
// a new command is taken while the last result beat still waits under rsp_stall;
// its result is held back until that beat leaves.

module cursor_linked_list_engine #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cll_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cll_pkg::rsp_type rsp_data
);
   import cll_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   cll_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   cll_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .req_data  (req_data),
      .rsp_data  (rsp_data)
   );

endmodule

// File: dv/testbench.sv
// self-checking testbench for cursor_linked_list_engine: insert, delete, get, locate
// a directed table, random phases and a fill to the full mark, checked by a list predictor
// depends on cll_pkg and the engine rtl
`timescale 1ns / 100ps

module testbench;
   import cll_pkg::*;

   localparam int LIST_DEPTH  = 1024;
   localparam int CYCLE_LIMIT = 12_000_000;

   typedef struct packed {
      logic    known;
      req_type item;
      rsp_type want;
   } table_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // list predictor state
   logic [POS_WIDTH-1:0]   next_link  [LIST_DEPTH];
   logic [VALUE_WIDTH-1:0] slot_value [LIST_DEPTH];
   int unsigned            model_count;
   logic [POS_WIDTH-1:0]   model_free;
   int unsigned            peak_count;

   rsp_type     expected_beats [$];
   rsp_type     want_beat;
   logic [VALUE_WIDTH-1:0] value_pool [8];
   bit          idle_on = 1'b1;
   int unsigned error_count = 0;
   int unsigned issued = 0;
   int unsigned checked = 0;
   int unsigned cycle_count = 0;

   // typed rows follow the list state by hand: [80000000, 7fffffff, 0] after the three inserts
   table_row_type directed_rows [24] = '{
      '{1'b1, '{CMD_GET,    10'd1,    32'h0},        '{32'h0, 10'd0, ST_RANGE, 10'd0}},
      '{1'b1, '{CMD_DELETE, 10'd1,    32'h0},        '{32'h0, 10'd0, ST_RANGE, 10'd0}},
      '{1'b1, '{CMD_DELETE, 10'd0,    32'h0},        '{32'h0, 10'd0, ST_RANGE, 10'd0}},
      '{1'b1, '{CMD_LOCATE, 10'd0,    32'h0},        '{32'h0, 10'd0, ST_OK,    10'd0}},
      '{1'b1, '{CMD_INSERT, 10'd0,    32'h5},        '{32'h0, 10'd0, ST_RANGE, 10'd0}},
      '{1'b1, '{CMD_INSERT, 10'd2,    32'h5},        '{32'h0, 10'd0, ST_RANGE, 10'd0}},
      '{1'b1, '{CMD_INSERT, 10'd1,    32'h7FFFFFFF}, '{32'h0, 10'd0, ST_OK,    10'd1}},
      '{1'b1, '{CMD_INSERT, 10'd1,    32'h80000000}, '{32'h0, 10'd0, ST_OK,    10'd2}},
      '{1'b1, '{CMD_INSERT, 10'd3,    32'h0},        '{32'h0, 10'd0, ST_OK,    10'd3}},
      '{1'b1, '{CMD_INSERT, 10'd5,    32'h1},        '{32'h0, 10'd0, ST_RANGE, 10'd3}},
      '{1'b1, '{CMD_INSERT, 10'd1023, 32'h1},        '{32'h0, 10'd0, ST_RANGE, 10'd3}},
      '{1'b1, '{CMD_GET,    10'd1,    32'h0},        '{32'h80000000, 10'd0, ST_OK, 10'd3}},
      '{1'b1, '{CMD_GET,    10'd3,    32'h0},        '{32'h0, 10'd0, ST_OK,    10'd3}},
      '{1'b1, '{CMD_GET,    10'd4,    32'h0},        '{32'h0, 10'd0, ST_RANGE, 10'd3}},
      '{1'b1, '{CMD_GET,    10'd1023, 32'h0},        '{32'h0, 10'd0, ST_RANGE, 10'd3}},
      '{1'b1, '{CMD_LOCATE, 10'd0,    32'h7FFFFFFF}, '{32'h0, 10'd2, ST_OK,    10'd3}},
      '{1'b1, '{CMD_LOCATE, 10'd1023, 32'hFFFFFFFF}, '{32'h0, 10'd0, ST_OK,    10'd3}},
      '{1'b0, '{CMD_INSERT, 10'd2,    32'hFFFFFFFF}, '0},
      '{1'b0, '{CMD_LOCATE, 10'd0,    32'h0},        '0},
      '{1'b0, '{CMD_DELETE, 10'd2,    32'h0},        '0},
      '{1'b0, '{CMD_DELETE, 10'd3,    32'h0},        '0},
      '{1'b0, '{CMD_INSERT, 10'd3,    32'h7FFFFFFF}, '0},
      '{1'b0, '{CMD_LOCATE, 10'd0,    32'h7FFFFFFF}, '0},
      '{1'b0, '{CMD_DELETE, 10'd1,    32'h0},        '0}
   };

   cursor_linked_list_engine #(
      .DEPTH      (LIST_DEPTH),
      .DATA_WIDTH (VALUE_WIDTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // slot reached after following a number of links from the head
   function automatic logic [POS_WIDTH-1:0] slot_after(input int unsigned steps);
      logic [POS_WIDTH-1:0] slot = '0;
      repeat (steps) slot = next_link[slot];
      return slot;
   endfunction

   function automatic rsp_type list_predict(input req_type item);
      rsp_type              beat;
      logic [POS_WIDTH-1:0] prev;
      logic [POS_WIDTH-1:0] slot;
      int unsigned          pos;
      beat = '0;
      pos  = 32'(item.position);
      case (item.cmd)
         CMD_INSERT: begin
            if (model_count >= LIST_DEPTH - 2) begin
               beat.status = ST_FULL;
            end else if (pos < 1 || pos > model_count + 1) begin
               beat.status = ST_RANGE;
            end else begin
               prev = slot_after(pos - 1);
               slot = model_free;
               model_free = next_link[slot];
               next_link[slot] = next_link[prev];
               next_link[prev] = slot;
               slot_value[slot] = item.value;
               model_count++;
            end
         end
         CMD_DELETE: begin
            if (pos < 1 || pos > model_count) begin
               beat.status = ST_RANGE;
            end else begin
               prev = slot_after(pos - 1);
               slot = next_link[prev];
               beat.result_value = slot_value[slot];
               next_link[prev] = next_link[slot];
               next_link[slot] = model_free;
               model_free = slot;
               model_count--;
            end
         end
         CMD_GET: begin
            if (pos < 1 || pos > model_count) beat.status = ST_RANGE;
            else beat.result_value = slot_value[slot_after(pos)];
         end
         CMD_LOCATE: begin
            slot = '0;
            for (int unsigned i = 1; i <= model_count; i++) begin
               slot = next_link[slot];
               if (slot_value[slot] == item.value) begin
                  beat.found_position = POS_WIDTH'(i);
                  break;
               end
            end
         end
      endcase
      beat.list_length = POS_WIDTH'(model_count);
      if (model_count > peak_count) peak_count = model_count;
      return beat;
   endfunction

   function automatic req_type make_req(input logic [CMD_WIDTH-1:0] cmd, input int unsigned pos,
                                        input logic [VALUE_WIDTH-1:0] val);
      req_type item;
      item.cmd      = cmd;
      item.position = POS_WIDTH'(pos);
      item.value    = val;
      return item;
   endfunction

   // mostly in-range positions and pooled values so that locate hits
   function automatic req_type random_item();
      req_type     item;
      int unsigned roll;
      int unsigned span;
      roll = $urandom_range(0, 9);
      item.cmd = (roll < 4) ? CMD_INSERT : (roll < 6) ? CMD_DELETE :
                 (roll < 8) ? CMD_GET : CMD_LOCATE;
      span = (item.cmd == CMD_INSERT) ? model_count + 1 : model_count;
      if (span == 0 || $urandom_range(0, 6) == 0)
         item.position = POS_WIDTH'($urandom_range(0, 1023));
      else item.position = POS_WIDTH'($urandom_range(1, span));
      item.value = $urandom_range(0, 1) ? value_pool[3'($urandom_range(0, 7))] : $urandom;
      return item;
   endfunction

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic issue(input req_type item, input logic known, input rsp_type want);
      rsp_type predicted;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predicted = list_predict(item);
      expected_beats.push_back(known ? want : predicted);
      issued++;
      @(negedge clock);
   endtask

   // receiver stall bursts
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) stall_left--;
         else if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 17);
         rsp_stall <= (stall_left > 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $error("rsp beat with nothing pending: %p", rsp_data);
            error_count++;
         end else begin
            want_beat = expected_beats.pop_front();
            checked++;
            if (rsp_data.result_value !== want_beat.result_value) begin
               $error("result_value expected %0d got %0d",
                      want_beat.result_value, rsp_data.result_value);
               error_count++;
            end
            if (rsp_data.found_position !== want_beat.found_position) begin
               $error("found_position expected %0d got %0d",
                      want_beat.found_position, rsp_data.found_position);
               error_count++;
            end
            if (rsp_data.status !== want_beat.status) begin
               $error("status expected %0d got %0d", want_beat.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.list_length !== want_beat.list_length) begin
               $error("list_length expected %0d got %0d",
                      want_beat.list_length, rsp_data.list_length);
               error_count++;
            end
         end
      end
   end

   initial begin
      logic [VALUE_WIDTH-1:0] last_fill_value;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      for (int k = 0; k < LIST_DEPTH; k++) begin
         next_link[k]  = POS_WIDTH'(k + 1);
         slot_value[k] = '0;
      end
      model_count = 0;
      model_free  = POS_WIDTH'(1);
      peak_count  = 0;
      value_pool[0] = 32'h80000000;
      value_pool[1] = 32'h7FFFFFFF;
      value_pool[2] = 32'h0;
      value_pool[3] = 32'hFFFFFFFF;
      for (int k = 4; k < 8; k++) value_pool[k] = $urandom;
      last_fill_value = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k])
         issue(directed_rows[k].item, directed_rows[k].known, directed_rows[k].want);

      repeat (250) issue(random_item(), 1'b0, '0);

      // sender holds off until every result is back
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      @(negedge clock);

      // fill to the full mark with cheap short walks
      while (model_count < LIST_DEPTH - 2) begin
         last_fill_value = $urandom;
         issue(make_req(CMD_INSERT, $urandom_range(1, (model_count < 8) ? model_count + 1 : 8),
                        last_fill_value), 1'b0, '0);
      end
      issue(make_req(CMD_INSERT, 1, 32'h1), 1'b0, '0);
      issue(make_req(CMD_INSERT, 0, 32'h1), 1'b0, '0);
      issue(make_req(CMD_INSERT, 1023, 32'h1), 1'b0, '0);
      issue(make_req(CMD_GET, LIST_DEPTH - 2, 32'h0), 1'b0, '0);
      issue(make_req(CMD_GET, LIST_DEPTH - 1, 32'h0), 1'b0, '0);
      issue(make_req(CMD_LOCATE, 0, last_fill_value), 1'b0, '0);
      issue(make_req(CMD_LOCATE, 0, $urandom), 1'b0, '0);
      issue(make_req(CMD_DELETE, LIST_DEPTH - 2, 32'h0), 1'b0, '0);
      issue(make_req(CMD_INSERT, LIST_DEPTH - 2, 32'h7FFFFFFF), 1'b0, '0);
      issue(make_req(CMD_INSERT, LIST_DEPTH - 1, 32'h0), 1'b0, '0);

      // drain back to a short list
      while (model_count > 16)
         issue(make_req(CMD_DELETE, $urandom_range(1, 8), 32'h0), 1'b0, '0);

      repeat (100) issue(random_item(), 1'b0, '0);
      idle_on = 1'b0;
      repeat (150) issue(random_item(), 1'b0, '0);

      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (32) @(posedge clock);

      $display("summary: %0d commands issued, %0d result beats checked, peak length %0d",
               issued, checked, peak_count);
      $display("summary: all four commands, range and full errors, random stalls on both sides");
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
